// ===== hdl/mmpid_pkg.sv =====
// Shared types, widths, codes and the per-mode multiply schedule of the PID controller.
package mmpid_pkg;

  // Fixed-point format of the gains
  localparam int FRAC_BITS = 8;

  // Datapath widths
  localparam int DATA_W = 16;                 // setpoint, gains, samples, drive
  localparam int LIM_W  = 15;                 // drive limit
  localparam int FUNC_W = 3;
  localparam int ERR_W  = DATA_W + 1;         // error
  localparam int DERR_W = ERR_W + 1;          // first difference
  localparam int D2_W   = ERR_W + 2;          // second difference
  localparam int MA_W   = DATA_W + 1;         // multiplier A operand (negated gain or error)
  localparam int MB_W   = 2 * ERR_W - FRAC_BITS; // multiplier B operand, wide enough for sq
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int TR_W   = ACC_W - FRAC_BITS;
  localparam int SUM_W  = TR_W + 1;
  localparam int IN_W   = 40;                 // input word, padded to whole bytes
  localparam int IDX_W  = 3;

  // Control laws
  localparam logic [FUNC_W-1:0] FUNC_PD        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PD_SPEED  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INC_PID   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_INC_ACCEL = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PD_GYRO   = 3'd4;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_P      = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_I      = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_D      = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN_SQUARE = 3'd4;
  localparam logic [IDX_W-1:0] REG_GAIN_RATE   = 3'd5;
  localparam logic [IDX_W-1:0] REG_LIMIT       = 3'd6;

  // Multiplier A operand selects
  localparam logic [2:0] A_GP   = 3'd0;
  localparam logic [2:0] A_GI   = 3'd1;
  localparam logic [2:0] A_GD   = 3'd2;
  localparam logic [2:0] A_GSQ  = 3'd3;
  localparam logic [2:0] A_GR   = 3'd4;
  localparam logic [2:0] A_ERR  = 3'd5;

  // Multiplier B operand selects
  localparam logic [2:0] B_ERR  = 3'd0;
  localparam logic [2:0] B_DERR = 3'd1;
  localparam logic [2:0] B_D2   = 3'd2;
  localparam logic [2:0] B_AUX  = 3'd3;
  localparam logic [2:0] B_SQ   = 3'd4;
  localparam logic [2:0] B_ABS  = 3'd5;

  // What happens to a product once it is registered
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_ACC  = 2'd1;
  localparam logic [1:0] K_SQ   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] a_sel;
    logic [2:0] b_sel;
    logic       neg;
    logic       last;
  } op_t;

  typedef struct packed {
    logic load;
    op_t  issue;
    logic trunc;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              out_busy;
  } dp_status_t;

  function automatic op_t mk_op(logic [1:0] kind, logic [2:0] a_sel, logic [2:0] b_sel,
                                logic neg, logic last);
    op_t o;
    o.kind  = kind;
    o.a_sel = a_sel;
    o.b_sel = b_sel;
    o.neg   = neg;
    o.last  = last;
    return o;
  endfunction

  // Multiply schedule per mode; the sq step comes first, so sq is stored before its use
  function automatic op_t op_lookup(logic [FUNC_W-1:0] func, logic [2:0] step);
    op_t o;
    o = mk_op(K_NONE, A_GP, B_ERR, 1'b0, 1'b1);
    unique case (func)
      FUNC_PD: begin
        unique case (step)
          3'd0:    o = mk_op(K_ACC, A_GP, B_ERR,  1'b0, 1'b0);
          default: o = mk_op(K_ACC, A_GD, B_DERR, 1'b1, 1'b1);
        endcase
      end
      FUNC_PD_SPEED: begin
        unique case (step)
          3'd0:    o = mk_op(K_SQ,  A_ERR, B_ABS, 1'b0, 1'b0);
          3'd1:    o = mk_op(K_ACC, A_GP,  B_ERR, 1'b0, 1'b0);
          3'd2:    o = mk_op(K_ACC, A_GD,  B_AUX, 1'b1, 1'b0);
          default: o = mk_op(K_ACC, A_GSQ, B_SQ,  1'b0, 1'b1);
        endcase
      end
      FUNC_INC_PID: begin
        unique case (step)
          3'd0:    o = mk_op(K_ACC, A_GP, B_DERR, 1'b0, 1'b0);
          3'd1:    o = mk_op(K_ACC, A_GI, B_ERR,  1'b0, 1'b0);
          default: o = mk_op(K_ACC, A_GD, B_D2,   1'b0, 1'b1);
        endcase
      end
      FUNC_INC_ACCEL: begin
        unique case (step)
          3'd0:    o = mk_op(K_ACC, A_GP, B_DERR, 1'b0, 1'b0);
          3'd1:    o = mk_op(K_ACC, A_GI, B_ERR,  1'b0, 1'b0);
          default: o = mk_op(K_ACC, A_GD, B_AUX,  1'b0, 1'b1);
        endcase
      end
      FUNC_PD_GYRO: begin
        unique case (step)
          3'd0:    o = mk_op(K_SQ,  A_ERR, B_ABS,  1'b0, 1'b0);
          3'd1:    o = mk_op(K_ACC, A_GP,  B_ERR,  1'b0, 1'b0);
          3'd2:    o = mk_op(K_ACC, A_GR,  B_AUX,  1'b1, 1'b0);
          3'd3:    o = mk_op(K_ACC, A_GD,  B_DERR, 1'b0, 1'b0);
          default: o = mk_op(K_ACC, A_GSQ, B_SQ,   1'b0, 1'b1);
        endcase
      end
      default: o = mk_op(K_NONE, A_GP, B_ERR, 1'b0, 1'b1);
    endcase
    return o;
  endfunction

endpackage

// ===== hdl/mmpid_ctrl.sv =====
// Sequencer of the PID controller: walks the multiply schedule and hands off the result.
module mmpid_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  mmpid_pkg::dp_status_t status,
  output mmpid_pkg::dp_cmd_t   cmd
);
  import mmpid_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;

  logic [2:0] state, state_next;
  logic [2:0] step, step_next;
  op_t        op;

  assign op = op_lookup(status.func, step);
  assign s_tready = (state == ST_IDLE);

  // Decode state into datapath commands
  always_comb begin
    state_next = state;
    step_next  = step;
    cmd.load   = 1'b0;
    cmd.issue  = mk_op(K_NONE, A_GP, B_ERR, 1'b0, 1'b0);
    cmd.trunc  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue = op;
        if (op.last) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_DRAIN: state_next = ST_TRUNC;
      ST_TRUNC: begin
        cmd.trunc  = 1'b1;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        // hold until the output register has room
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== hdl/mmpid_dp.sv =====
// Datapath of the PID controller: registers, error terms, shared multiplier, clamp and output.
module mmpid_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mmpid_pkg::IDX_W-1:0] cfg_index,
  input  logic [mmpid_pkg::DATA_W-1:0] cfg_data,
  input  logic [mmpid_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mmpid_pkg::DATA_W-1:0] m_tdata,
  input  mmpid_pkg::dp_cmd_t          cmd,
  output mmpid_pkg::dp_status_t       status
);
  import mmpid_pkg::*;

  // Configuration
  logic signed [DATA_W-1:0] setpoint, gain_p, gain_i, gain_d, gain_square, gain_rate;
  logic        [LIM_W-1:0]  drive_limit;

  // Loop history
  logic signed [ERR_W-1:0]  prev_error, prev_prev_error;
  logic signed [DATA_W-1:0] prev_drive;

  // Per-sample operands
  logic [FUNC_W-1:0]        func;
  logic signed [ERR_W-1:0]  err;
  logic        [ERR_W-1:0]  abs_err;
  logic signed [DERR_W-1:0] derr;
  logic signed [D2_W-1:0]   d2;
  logic signed [DATA_W-1:0] aux;
  logic signed [MB_W-1:0]   sq;

  // Multiply / accumulate
  logic signed [MA_W-1:0]   a_raw, a_op;
  logic signed [MB_W-1:0]   b_op;
  logic signed [PROD_W-1:0] prod;
  logic [1:0]               prod_kind;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lim_pos, clamped;
  logic                     incr;

  // Unpacked input word
  logic [FUNC_W-1:0]        in_func;
  logic signed [DATA_W-1:0] in_meas, in_aux;
  logic signed [ERR_W-1:0]  in_err;

  assign in_func = s_tdata[FUNC_W-1:0];
  assign in_meas = s_tdata[FUNC_W +: DATA_W];
  assign in_aux  = s_tdata[FUNC_W+DATA_W +: DATA_W];
  assign in_err  = ERR_W'(setpoint) - ERR_W'(in_meas);

  assign incr = (func inside {FUNC_INC_PID, FUNC_INC_ACCEL});

  assign status.func     = func;
  assign status.out_busy = m_tvalid && !m_tready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= '0;
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      gain_square <= '0;
      gain_rate   <= '0;
      drive_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETPOINT:    setpoint    <= cfg_data;
        REG_GAIN_P:      gain_p      <= cfg_data;
        REG_GAIN_I:      gain_i      <= cfg_data;
        REG_GAIN_D:      gain_d      <= cfg_data;
        REG_GAIN_SQUARE: gain_square <= cfg_data;
        REG_GAIN_RATE:   gain_rate   <= cfg_data;
        REG_LIMIT:       drive_limit <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the sample and form the error terms
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func    <= in_func;
      aux     <= in_aux;
      err     <= in_err;
      abs_err <= in_err[ERR_W-1] ? ERR_W'(-in_err) : ERR_W'(in_err);
      derr    <= DERR_W'(in_err) - DERR_W'(prev_error);
      d2      <= D2_W'(in_err) - (D2_W'(prev_error) <<< 1) + D2_W'(prev_prev_error);
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd.issue.a_sel)
      A_GP:    a_raw = MA_W'(gain_p);
      A_GI:    a_raw = MA_W'(gain_i);
      A_GD:    a_raw = MA_W'(gain_d);
      A_GSQ:   a_raw = MA_W'(gain_square);
      A_GR:    a_raw = MA_W'(gain_rate);
      A_ERR:   a_raw = MA_W'(err);
      default: a_raw = '0;
    endcase
    a_op = cmd.issue.neg ? -a_raw : a_raw;
    unique case (cmd.issue.b_sel)
      B_ERR:   b_op = MB_W'(err);
      B_DERR:  b_op = MB_W'(derr);
      B_D2:    b_op = MB_W'(d2);
      B_AUX:   b_op = MB_W'(aux);
      B_SQ:    b_op = sq;
      B_ABS:   b_op = MB_W'($signed({1'b0, abs_err}));
      default: b_op = '0;
    endcase
  end

  // Multiply into prod, then accumulate the registered product or store it as sq
  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
    if (cmd.load) begin
      acc <= '0;
    end else if (prod_kind == K_ACC) begin
      acc <= acc + ACC_W'(prod);
    end
    if (prod_kind == K_SQ) begin
      // shift right truncating toward zero
      sq <= MB_W'((prod + (prod[PROD_W-1] ? PROD_W'((1 << FRAC_BITS) - 1) : PROD_W'(0)))
                  >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      prod_kind <= K_NONE;
    end else begin
      prod_kind <= cmd.issue.kind;
    end
  end

  // Scale the sum and add the last drive in incremental modes
  always_ff @(posedge clk) begin
    if (cmd.trunc) begin
      sum <= SUM_W'(TR_W'((acc + (acc[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : ACC_W'(0)))
                          >>> FRAC_BITS))
           + (incr ? SUM_W'(prev_drive) : SUM_W'(0));
    end
  end

  // Clamp symmetrically to the limit
  always_comb begin
    lim_pos = SUM_W'($signed({1'b0, drive_limit}));
    if (sum > lim_pos) begin
      clamped = lim_pos;
    end else if (sum < -lim_pos) begin
      clamped = -lim_pos;
    end else begin
      clamped = sum;
    end
  end

  // Commit history and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error      <= '0;
      prev_prev_error <= '0;
      prev_drive      <= '0;
    end else if (cmd.commit) begin
      unique case (func) inside
        FUNC_PD, FUNC_PD_SPEED, FUNC_PD_GYRO: prev_error <= err;
        FUNC_INC_PID, FUNC_INC_ACCEL: begin
          prev_prev_error <= prev_error;
          prev_error      <= err;
          prev_drive      <= DATA_W'(clamped);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= DATA_W'(clamped);
    end
  end

endmodule

// ===== hdl/multi_mode_pid_controller_top.sv =====
// Top level of the multi-mode PID controller: sequencer plus datapath.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata: func[2:0] measured[18:3] aux[34:19]
//  m_      | out | m_tvalid/m_tready | m_tdata: drive[15:0]
//  cfg_    | in  | cfg_we            | cfg_index, cfg_data (register write)
//
// A sample passes through load, one slot for each step of the mode's multiply
// schedule on the single shared 17x26 multiplier (1 to 5; an undefined mode runs
// one empty slot), drain, scale, clamp.
// One sample is in flight at a time; s_tready is high only when the block is idle.
// The output register holds a finished word; a new sample is taken while it waits,
// and that sample stalls at the clamp step until the word is taken.
// Reset (rst, synchronous) clears the configuration registers, loop history and m_tvalid.
module multi_mode_pid_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mmpid_pkg::IDX_W-1:0]   cfg_index,
  input  logic [mmpid_pkg::DATA_W-1:0]  cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [mmpid_pkg::IN_W-1:0]    s_tdata,   // func, measured, aux_sensor, zero pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mmpid_pkg::DATA_W-1:0]  m_tdata    // drive
);
  import mmpid_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mmpid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mmpid_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== hdl/mmpid_checker.sv =====
// Port-level checks of the PID controller and their bind to the top level.
module mmpid_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_we,
  input logic [mmpid_pkg::IDX_W-1:0]  cfg_index,
  input logic [mmpid_pkg::DATA_W-1:0] cfg_data,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [mmpid_pkg::DATA_W-1:0] m_tdata
);
  import mmpid_pkg::*;

  logic        [LIM_W-1:0]  limit;
  logic signed [DATA_W-1:0] lim_s, drive_s;

  // Track the limit as written on the port
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= '0;
    end else if (cfg_we && cfg_index == REG_LIMIT) begin
      limit <= cfg_data[LIM_W-1:0];
    end
  end

  assign lim_s   = $signed({1'b0, limit});
  assign drive_s = $signed(m_tdata);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid set after reset");

  // A stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // Every drive is inside the limit
  a_in_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (drive_s <= lim_s) && (drive_s >= -lim_s))
    else $error("drive outside the limit");

  // One sample at a time: no accept right after an accept
  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

endmodule

bind multi_mode_pid_controller_top mmpid_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

// ===== tb/sv/tb_multi_mode_pid_controller_top.sv =====
// Self-checking testbench of the multi-mode PID controller: predictor, stimulus and checks.
`timescale 1ns / 100ps

module tb_multi_mode_pid_controller_top;
  import mmpid_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no transfer before the run is dropped
  localparam int HOLD_OFF      = 300;   // long receiver hold-off of the back-pressure test
  localparam int SETTLE_CYCLES = 12;    // pipeline depth plus margin

  typedef struct {
    logic [DATA_W-1:0] drive;
    logic [FUNC_W-1:0] func;
  } drive_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [DATA_W-1:0]   cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;   // func[2:0] measured[18:3] aux[34:19] zero pad
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [DATA_W-1:0]   m_tdata;        // drive[15:0]

  // Shadow registers of the controller
  logic signed [DATA_W-1:0] setpoint_r, kp_r, ki_r, kd_r, ksq_r, krate_r;
  logic [LIM_W-1:0]         limit_r;
  // Shadow loop history
  logic signed [ERR_W-1:0]  last_err, older_err;
  logic signed [DATA_W-1:0] last_drive;

  drive_word_t pending_drive_q[$];

  int  errors = 0;
  int  samples_sent = 0;
  int  words_checked = 0;
  int  settings_used = 0;
  bit  idle_on = 1'b1;
  int  hold_req = 0;
  int  quiet_cycles = 0;

  multi_mode_pid_controller_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shift right by the fraction bits, rounding toward zero
  function automatic longint trunc_frac(longint x);
    if (x < 0) return -((-x) >> FRAC_BITS);
    return x >> FRAC_BITS;
  endfunction

  function automatic longint clamp_limit(longint x);
    longint lim;
    lim = longint'(limit_r);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Work out the drive of one sample and advance the shadow loop history
  function automatic logic [DATA_W-1:0] predict_drive(logic [FUNC_W-1:0] fn,
                                                      logic signed [DATA_W-1:0] meas,
                                                      logic signed [DATA_W-1:0] aux);
    longint e, de, ae, sq, d2, acc, drv;
    e   = longint'(setpoint_r) - longint'(meas);
    de  = e - longint'(last_err);
    ae  = (e < 0) ? -e : e;
    sq  = trunc_frac(e * ae);
    d2  = e - 2 * longint'(last_err) + longint'(older_err);
    drv = 0;
    case (fn) inside
      FUNC_PD: begin
        acc = longint'(kp_r) * e - longint'(kd_r) * de;
        drv = clamp_limit(trunc_frac(acc));
        last_err = e[ERR_W-1:0];
      end
      FUNC_PD_SPEED: begin
        acc = longint'(kp_r) * e - longint'(kd_r) * longint'(aux) + longint'(ksq_r) * sq;
        drv = clamp_limit(trunc_frac(acc));
        last_err = e[ERR_W-1:0];
      end
      FUNC_INC_PID, FUNC_INC_ACCEL: begin
        if (fn == FUNC_INC_PID)
          acc = longint'(kp_r) * de + longint'(ki_r) * e + longint'(kd_r) * d2;
        else
          acc = longint'(kp_r) * de + longint'(ki_r) * e + longint'(kd_r) * longint'(aux);
        drv = clamp_limit(trunc_frac(acc) + longint'(last_drive));
        older_err  = last_err;
        last_err   = e[ERR_W-1:0];
        last_drive = drv[DATA_W-1:0];
      end
      FUNC_PD_GYRO: begin
        acc = longint'(kp_r) * e - longint'(krate_r) * longint'(aux)
            + longint'(ksq_r) * sq + longint'(kd_r) * de;
        drv = clamp_limit(trunc_frac(acc));
        last_err = e[ERR_W-1:0];
      end
      default: drv = 0;  // undefined mode leaves the history alone
    endcase
    return drv[DATA_W-1:0];
  endfunction

  // Biased 16-bit value: extremes, small magnitudes and full range
  function automatic logic [DATA_W-1:0] pick16(int small_mag);
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4, 5:    return DATA_W'($urandom_range(0, 2 * small_mag) - small_mag);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // Drive one register write; the caller lowers the write enable
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Write every register and mirror the new setting
  task automatic load_settings(logic [DATA_W-1:0] sp, logic [DATA_W-1:0] p,
                               logic [DATA_W-1:0] i, logic [DATA_W-1:0] d,
                               logic [DATA_W-1:0] sq, logic [DATA_W-1:0] r,
                               logic [DATA_W-1:0] lim);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_GAIN_SQUARE, sq);
    write_reg(REG_GAIN_RATE, r);
    write_reg(REG_LIMIT, lim);
    cfg_we     <= 1'b0;
    setpoint_r = sp;
    kp_r       = p;
    ki_r       = i;
    kd_r       = d;
    ksq_r      = sq;
    krate_r    = r;
    limit_r    = lim[LIM_W-1:0];
    settings_used++;
  endtask

  // Offer one sample word, wait for its transfer and queue its drive
  task automatic send_sample(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] meas,
                             logic [DATA_W-1:0] aux);
    int gap;
    drive_word_t w;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {{(IN_W - FUNC_W - 2 * DATA_W){1'b0}}, aux, meas, fn};
    s_tvalid <= 1'b1;
    do @(negedge clk); while (s_tready !== 1'b1);
    @(posedge clk);
    w.func  = fn;
    w.drive = predict_drive(fn, meas, aux);
    pending_drive_q.push_back(w);
    samples_sent++;
  endtask

  // Let every queued drive word come out, then let the pipeline settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random setting, extremes included now and then
  task automatic load_random_settings();
    logic [DATA_W-1:0] lim;
    case ($urandom_range(0, 5))
      0:       lim = 16'h0000;
      1:       lim = 16'h7FFF;
      2:       lim = DATA_W'($urandom_range(1, 200));
      default: lim = DATA_W'($urandom_range(0, 32767));
    endcase
    lim[15] = 1'($urandom_range(0, 1));
    load_settings(pick16(300), pick16(1024), pick16(1024), pick16(1024),
                  pick16(64), pick16(1024), lim);
  endtask

  // Bursts of one mode with about half of the measurements near the setpoint
  task automatic run_random_bursts(int count);
    logic [FUNC_W-1:0] fn;
    logic [DATA_W-1:0] meas;
    int burst, left;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 8) fn = FUNC_W'($urandom_range(5, 7));
      else fn = FUNC_W'($urandom_range(FUNC_PD, FUNC_PD_GYRO));
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if (left > 0) begin
          if ($urandom_range(0, 1))
            meas = setpoint_r + DATA_W'($urandom_range(0, 600) - 300);
          else
            meas = pick16(500);
          send_sample(fn, meas, pick16(500));
          left--;
        end
      end
    end
  endtask

  // All registers at zero after reset: every mode gives zero drive
  task automatic test_reset_state();
    send_sample(FUNC_PD, 16'h8000, 16'h7FFF);
    send_sample(FUNC_INC_PID, 16'h7FFF, 16'h8000);
    send_sample(FUNC_PD_GYRO, 16'h1234, 16'hFEDC);
    wait_idle();
  endtask

  // Extreme gains and errors in every mode, undefined modes, zero limit
  task automatic test_directed_extremes();
    // Largest positive error against the largest gains
    load_settings(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(FUNC_PD, 16'h8000, 16'h7FFF);
    send_sample(FUNC_PD_SPEED, 16'h8000, 16'h8000);
    send_sample(FUNC_INC_PID, 16'h8000, 16'h7FFF);
    send_sample(FUNC_INC_ACCEL, 16'h8000, 16'h8000);
    send_sample(FUNC_PD_GYRO, 16'h8000, 16'h7FFF);
    // Undefined modes hold the history
    send_sample(3'd5, 16'h7FFF, 16'h7FFF);
    send_sample(3'd6, 16'h0000, 16'h8000);
    send_sample(3'd7, 16'h8000, 16'hFFFF);
    wait_idle();
    // Largest negative error, unity gains, moderate limit
    load_settings(16'h8000, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'd1000);
    send_sample(FUNC_PD, 16'h7FFF, 16'h0000);
    send_sample(FUNC_PD_SPEED, 16'h7FFF, 16'h7FFF);
    send_sample(FUNC_INC_PID, 16'h7FFF, 16'h8000);
    send_sample(FUNC_INC_ACCEL, 16'h7FFF, 16'h7FFF);
    send_sample(FUNC_PD_GYRO, 16'h7FFF, 16'h8000);
    wait_idle();
    // Zero limit pins the drive at zero; bit 15 of the limit write is dropped
    load_settings(16'h0040, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_sample(FUNC_PD, 16'h8000, 16'h0000);
    send_sample(FUNC_INC_PID, 16'h8000, 16'h0000);
    send_sample(FUNC_PD_GYRO, 16'h7FFF, 16'h8000);
    wait_idle();
  endtask

  // Random settings and bursts with random gaps on both sides
  task automatic test_random_settings();
    repeat (8) begin
      load_random_settings();
      run_random_bursts(85);
      wait_idle();
    end
  endtask

  // Back-to-back words with neither side idling
  task automatic test_streaming();
    idle_on = 1'b0;
    load_random_settings();
    run_random_bursts(100);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_back_pressure();
    idle_on = 1'b0;
    load_settings(16'h0000, 16'h0180, 16'h0040, 16'h0020, 16'h0008, 16'h0100, 16'h7FFF);
    hold_req = HOLD_OFF;
    run_random_bursts(60);
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Take drive words with random stalls and compare with the oldest prediction
  initial begin : drive_checker
    int stall;
    logic [DATA_W-1:0] got;
    drive_word_t want;
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 14) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (m_tvalid !== 1'b1);
      got = m_tdata;
      @(posedge clk);
      if (pending_drive_q.size() == 0) begin
        $display("%0t: drive word with no prediction waiting, got %0d",
                 $time, $signed(got));
        errors++;
      end else begin
        want = pending_drive_q.pop_front();
        if (got !== want.drive) begin
          $display("%0t: drive mismatch (func %0d), expected %0d, got %0d",
                   $time, want.func, $signed(want.drive), $signed(got));
          errors++;
        end
        words_checked++;
      end
    end
  end

  // Drop the run when nothing moves for too long
  always @(negedge clk) begin
    if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : test_sequence
    setpoint_r = '0; kp_r = '0; ki_r = '0; kd_r = '0; ksq_r = '0; krate_r = '0;
    limit_r    = '0;
    last_err   = '0; older_err = '0; last_drive = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_extremes();
    test_random_settings();
    test_streaming();
    test_back_pressure();

    wait_idle();
    if (pending_drive_q.size() != 0) begin
      $display("%0t: %0d predicted drive words never arrived", $time, pending_drive_q.size());
      errors++;
    end
    $display("Sent %0d samples over %0d register settings, checked %0d drive words.",
             samples_sent, settings_used, words_checked);
    $display("Covered all five laws, undefined modes, zero limit, streaming %s",
             $sformatf("and a %0d-cycle hold-off.", HOLD_OFF));
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mmpid_pkg.sv
hdl/mmpid_ctrl.sv
hdl/mmpid_dp.sv
hdl/multi_mode_pid_controller_top.sv
hdl/mmpid_checker.sv
tb/sv/tb_multi_mode_pid_controller_top.sv
